### rtl/core/dsa_pkg.sv
// Package with the sizes, types and codes shared by the decimal string adder.
package dsa_pkg;

    localparam int MAX_DIGITS = 256;
    localparam int SUM_DEPTH  = MAX_DIGITS + 2;
    localparam int DIG_AW     = $clog2(MAX_DIGITS);
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
    localparam int SUM_AW     = $clog2(SUM_DEPTH);
    localparam int W_W        = $clog2(2 * MAX_DIGITS + 2);
    localparam int IDX_W      = W_W + 1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef logic [3:0]        t_digit;
    typedef logic [DIG_AW-1:0] t_dig_addr;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [SUM_AW-1:0] t_sum_addr;
    typedef logic [W_W-1:0]    t_width;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_DIGIT,
        PH_POINT,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAYOUT,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_FINISH,
        ST_EMIT,
        ST_OUT
    } t_state;

endpackage

### rtl/core/dsa_if.sv
// Valid/ready channel interfaces for the request and result streams.
interface dsa_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic       operand_sel;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output req_type, output operand_sel,
                    output char_code, output last_char, input ready);
    modport sink (input valid, input req_type, input operand_sel,
                  input char_code, input last_char, output ready);
endinterface

interface dsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;
    logic       out_none;

    modport source (output valid, output out_char, output out_last,
                    output out_none, input ready);
    modport sink (input valid, input out_char, input out_last,
                  input out_none, output ready);
endinterface

### rtl/core/dsa_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module dsa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 4,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/dsa_bcd_unit.sv
// One BCD digit adder with carry in and carry out, shared by every place.
module dsa_bcd_unit (
    input  dsa_pkg::t_digit i_a,
    input  dsa_pkg::t_digit i_b,
    input  logic            i_cin,
    output dsa_pkg::t_digit o_sum,
    output logic            o_cout
);
    logic [4:0] w_raw;

    assign w_raw  = {1'b0, i_a} + {1'b0, i_b} + {4'b0, i_cin};
    assign o_cout = (w_raw >= 5'd10);
    assign o_sum  = o_cout ? dsa_pkg::t_digit'(w_raw - 5'd10) : w_raw[3:0];
endmodule

### rtl/core/decimal_string_adder.sv
// Top level of the decimal string adder: request decoding, add sequencer and result port.
//
// Load requests store one operand character each. The load that ends the second
// operand starts the addition: a layout state, then for each aligned digit place an
// operand store read, then the shared BCD adder and the sum store write, then a
// finishing state. The sum is W places wide, W being the larger integer part plus the
// larger fraction plus one. A fetch of a sum digit reads the sum store in ST_EMIT before
// ST_OUT, a fetch of the point or of no character goes straight to ST_OUT, and each
// result waits at the output until it is taken. Zero trimming is tracked during the
// digit walk, so no extra pass is needed. The stores need no clearing.
module decimal_string_adder (
    input logic      i_clk,
    input logic      i_rst_n,
    dsa_in_if.sink   i_in,
    dsa_out_if.source o_out
);
    dsa_pkg::t_state r_state, n_state;
    dsa_pkg::t_phase r_phase, n_phase;

    dsa_pkg::t_len      r_len1, n_len1, r_len2, n_len2;
    dsa_pkg::t_len      r_frac1, n_frac1, r_frac2, n_frac2;
    logic [1:0]         r_pt, n_pt;
    dsa_pkg::t_len      r_int1, n_int1, r_int2, n_int2;
    dsa_pkg::t_len      r_fmax, n_fmax;
    dsa_pkg::t_width    r_w, n_w, r_d, n_d, r_p, n_p;
    dsa_pkg::t_sum_addr r_fe, n_fe;
    logic               r_carry, n_carry;
    logic               r_v1, n_v1, r_v2, n_v2;
    dsa_pkg::t_sum_addr r_hi, n_hi, r_lo, n_lo;
    logic               r_hi_any, n_hi_any, r_lo_any, n_lo_any;
    dsa_pkg::t_sum_addr r_pos, n_pos, r_low, n_low;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic       r_out_last, n_out_last, r_out_none, n_out_none;

    logic w_acc, w_load, w_fetch, w_digit, w_pt_char;
    dsa_pkg::t_len   w_len, w_frac;
    logic [1:0]      w_pt;
    logic            w_bit;
    logic            w_we1, w_we2, w_swe;
    dsa_pkg::t_idx   w_idx1, w_idx2;
    dsa_pkg::t_digit w_rd1, w_rd2, w_srd, w_a, w_b, w_s;
    logic            w_cout;
    dsa_pkg::t_sum_addr w_q;
    dsa_pkg::t_len   w_imax;
    dsa_pkg::t_width w_wid;

    assign i_in.ready  = (r_state == dsa_pkg::ST_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_load      = w_acc && (i_in.req_type == dsa_pkg::REQ_LOAD);
    assign w_fetch     = w_acc && (i_in.req_type == dsa_pkg::REQ_FETCH);
    assign w_digit     = (i_in.char_code >= dsa_pkg::CHAR_ZERO) &&
                         (i_in.char_code <= dsa_pkg::CHAR_NINE);
    assign w_pt_char   = (i_in.char_code == dsa_pkg::CHAR_POINT);

    // A load after an addition starts a new problem from cleared counters.
    always_comb begin
        logic fresh;
        fresh  = (r_phase != dsa_pkg::PH_LOAD);
        w_pt   = fresh ? 2'b00 : r_pt;
        w_len  = fresh ? '0 : (i_in.operand_sel ? r_len2 : r_len1);
        w_frac = fresh ? '0 : (i_in.operand_sel ? r_frac2 : r_frac1);
        w_bit  = w_pt[i_in.operand_sel];
    end

    assign w_we1 = w_load && w_digit && !i_in.operand_sel &&
                   (w_len < dsa_pkg::t_len'(dsa_pkg::MAX_DIGITS));
    assign w_we2 = w_load && w_digit && i_in.operand_sel &&
                   (w_len < dsa_pkg::t_len'(dsa_pkg::MAX_DIGITS));

    // Operand index of aligned place p: integer part - 1 + fmax - p.
    assign w_idx1 = dsa_pkg::t_idx'(r_int1) + dsa_pkg::t_idx'(r_fmax)
                  - dsa_pkg::t_idx'(r_p) - dsa_pkg::t_idx'(1);
    assign w_idx2 = dsa_pkg::t_idx'(r_int2) + dsa_pkg::t_idx'(r_fmax)
                  - dsa_pkg::t_idx'(r_p) - dsa_pkg::t_idx'(1);

    dsa_ram #(.DEPTH(dsa_pkg::MAX_DIGITS), .WIDTH(4)) u_ram_first (
        .i_clk(i_clk), .i_we(w_we1), .i_waddr(dsa_pkg::t_dig_addr'(w_len)),
        .i_wdata(dsa_pkg::t_digit'(i_in.char_code - dsa_pkg::CHAR_ZERO)),
        .i_raddr(dsa_pkg::t_dig_addr'(w_idx1)), .o_rdata(w_rd1)
    );

    dsa_ram #(.DEPTH(dsa_pkg::MAX_DIGITS), .WIDTH(4)) u_ram_second (
        .i_clk(i_clk), .i_we(w_we2), .i_waddr(dsa_pkg::t_dig_addr'(w_len)),
        .i_wdata(dsa_pkg::t_digit'(i_in.char_code - dsa_pkg::CHAR_ZERO)),
        .i_raddr(dsa_pkg::t_dig_addr'(w_idx2)), .o_rdata(w_rd2)
    );

    assign w_a = r_v1 ? w_rd1 : '0;
    assign w_b = r_v2 ? w_rd2 : '0;

    dsa_bcd_unit u_bcd (
        .i_a(w_a), .i_b(w_b), .i_cin(r_carry), .o_sum(w_s), .o_cout(w_cout)
    );

    assign w_q   = dsa_pkg::t_sum_addr'(r_p - r_d);
    assign w_swe = (r_state == dsa_pkg::ST_ADD_WR) && (r_p >= r_d);

    dsa_ram #(.DEPTH(dsa_pkg::SUM_DEPTH), .WIDTH(4)) u_ram_sum (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(w_q), .i_wdata(w_s),
        .i_raddr(r_pos), .o_rdata(w_srd)
    );

    assign w_imax = (r_int1 > r_int2) ? r_int1 : r_int2;
    assign w_wid  = dsa_pkg::t_width'(r_fmax) + dsa_pkg::t_width'(w_imax)
                  + dsa_pkg::t_width'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsa_pkg::ST_IDLE: begin
                if (w_load && i_in.last_char && i_in.operand_sel) begin
                    n_state = dsa_pkg::ST_LAYOUT;
                end else if (w_fetch) begin
                    n_state = (r_phase == dsa_pkg::PH_DIGIT) ? dsa_pkg::ST_EMIT
                                                             : dsa_pkg::ST_OUT;
                end
            end
            dsa_pkg::ST_LAYOUT: n_state = dsa_pkg::ST_ADD_RD;
            dsa_pkg::ST_ADD_RD: n_state = dsa_pkg::ST_ADD_WR;
            dsa_pkg::ST_ADD_WR: begin
                n_state = (r_p == r_w - dsa_pkg::t_width'(1)) ? dsa_pkg::ST_FINISH
                                                              : dsa_pkg::ST_ADD_RD;
            end
            dsa_pkg::ST_FINISH: n_state = dsa_pkg::ST_IDLE;
            dsa_pkg::ST_EMIT:   n_state = dsa_pkg::ST_OUT;
            dsa_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_state = dsa_pkg::ST_IDLE;
                end
            end
            default: n_state = dsa_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output updates.
    always_comb begin
        n_phase = r_phase;
        n_len1 = r_len1;  n_len2 = r_len2;
        n_frac1 = r_frac1; n_frac2 = r_frac2;
        n_pt = r_pt;
        n_int1 = r_int1; n_int2 = r_int2; n_fmax = r_fmax;
        n_w = r_w; n_d = r_d; n_p = r_p; n_fe = r_fe;
        n_carry = r_carry; n_v1 = r_v1; n_v2 = r_v2;
        n_hi = r_hi; n_lo = r_lo; n_hi_any = r_hi_any; n_lo_any = r_lo_any;
        n_pos = r_pos; n_low = r_low;
        n_out_valid = r_out_valid; n_out_char = r_out_char;
        n_out_last = r_out_last; n_out_none = r_out_none;
        unique case (r_state)
            dsa_pkg::ST_IDLE: begin
                if (w_load) begin
                    n_phase = dsa_pkg::PH_LOAD;
                    if (r_phase != dsa_pkg::PH_LOAD) begin
                        n_len1 = '0; n_len2 = '0; n_frac1 = '0; n_frac2 = '0;
                        n_pos = '0; n_low = '0; n_carry = 1'b0;
                    end
                    n_pt = w_pt;
                    if (w_pt_char) begin
                        n_pt[i_in.operand_sel] = 1'b1;
                    end else if (w_we1 || w_we2) begin
                        if (i_in.operand_sel) begin
                            n_len2  = w_len + dsa_pkg::t_len'(1);
                            n_frac2 = w_bit ? w_frac + dsa_pkg::t_len'(1) : w_frac;
                        end else begin
                            n_len1  = w_len + dsa_pkg::t_len'(1);
                            n_frac1 = w_bit ? w_frac + dsa_pkg::t_len'(1) : w_frac;
                        end
                    end
                end else if (w_fetch) begin
                    n_out_char = 8'h00;
                    n_out_last = 1'b0;
                    n_out_none = 1'b0;
                    if (r_phase == dsa_pkg::PH_POINT) begin
                        n_out_char  = dsa_pkg::CHAR_POINT;
                        n_phase     = dsa_pkg::PH_DIGIT;
                        n_out_valid = 1'b1;
                    end else if (r_phase != dsa_pkg::PH_DIGIT) begin
                        n_out_none  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            dsa_pkg::ST_LAYOUT: begin
                n_int1 = r_len1 - r_frac1;
                n_int2 = r_len2 - r_frac2;
                n_fmax = (r_frac1 > r_frac2) ? r_frac1 : r_frac2;
                n_p = '0; n_carry = 1'b0;
                n_hi_any = 1'b0; n_lo_any = 1'b0;
            end
            dsa_pkg::ST_ADD_RD: begin
                if (r_p == '0) begin
                    n_w = w_wid;
                    n_d = (w_wid > dsa_pkg::t_width'(dsa_pkg::SUM_DEPTH)) ?
                          w_wid - dsa_pkg::t_width'(dsa_pkg::SUM_DEPTH) : '0;
                    n_fe = dsa_pkg::t_sum_addr'(dsa_pkg::t_width'(r_fmax) -
                          ((w_wid > dsa_pkg::t_width'(dsa_pkg::SUM_DEPTH)) ?
                           w_wid - dsa_pkg::t_width'(dsa_pkg::SUM_DEPTH) : '0));
                end
                n_v1 = !w_idx1[dsa_pkg::IDX_W-1] &&
                       (w_idx1 < dsa_pkg::t_idx'(r_len1));
                n_v2 = !w_idx2[dsa_pkg::IDX_W-1] &&
                       (w_idx2 < dsa_pkg::t_idx'(r_len2));
            end
            dsa_pkg::ST_ADD_WR: begin
                n_carry = w_cout;
                n_p = r_p + dsa_pkg::t_width'(1);
                if (w_swe && (w_s != '0)) begin
                    n_hi = w_q;
                    n_hi_any = 1'b1;
                    if (!r_lo_any) begin
                        n_lo = w_q;
                        n_lo_any = 1'b1;
                    end
                end
            end
            dsa_pkg::ST_FINISH: begin
                n_pos = (r_hi_any && r_hi > r_fe) ? r_hi : r_fe;
                n_low = (r_lo_any && r_lo < r_fe) ? r_lo : r_fe;
                n_phase = dsa_pkg::PH_DIGIT;
            end
            dsa_pkg::ST_EMIT: begin
                n_out_valid = 1'b1;
                n_out_char  = {4'h3, w_srd};
                if (r_pos <= r_low) begin
                    n_out_last = 1'b1;
                    n_phase = dsa_pkg::PH_DONE;
                end else begin
                    if (r_pos == r_fe) begin
                        n_phase = dsa_pkg::PH_POINT;
                    end
                    n_pos = r_pos - dsa_pkg::t_sum_addr'(1);
                end
            end
            dsa_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsa_pkg::ST_IDLE;
            r_phase <= dsa_pkg::PH_LOAD;
            r_len1 <= '0; r_len2 <= '0; r_frac1 <= '0; r_frac2 <= '0;
            r_pt <= '0; r_carry <= 1'b0;
            r_pos <= '0; r_low <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_len1 <= n_len1; r_len2 <= n_len2;
            r_frac1 <= n_frac1; r_frac2 <= n_frac2;
            r_pt <= n_pt; r_carry <= n_carry;
            r_pos <= n_pos; r_low <= n_low;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_int1 <= n_int1; r_int2 <= n_int2; r_fmax <= n_fmax;
        r_w <= n_w; r_d <= n_d; r_p <= n_p; r_fe <= n_fe;
        r_v1 <= n_v1; r_v2 <= n_v2;
        r_hi <= n_hi; r_lo <= n_lo; r_hi_any <= n_hi_any; r_lo_any <= n_lo_any;
        r_out_char <= n_out_char; r_out_last <= n_out_last; r_out_none <= n_out_none;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.out_last = r_out_last;
    assign o_out.out_none = r_out_none;
endmodule

### dv/decimal_string_adder_tb.sv
// Self-checking testbench for the decimal string adder: directed and random sums.
`timescale 1ns / 100ps

module decimal_string_adder_tb;

    typedef logic [7:0] t_chars[$];

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        logic       none;
    } t_sum_char;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1850;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dsa_in_if  req_ch ();
    dsa_out_if sum_ch ();

    decimal_string_adder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (sum_ch)
    );

    always #10 i_clk = ~i_clk;

    // Shadow state of the adder.
    logic [3:0] dig_a [dsa_pkg::MAX_DIGITS];
    logic [3:0] dig_b [dsa_pkg::MAX_DIGITS];
    logic [3:0] sum_dig [dsa_pkg::SUM_DEPTH];
    int         len_a, len_b, frac_a, frac_b, frac_kept;
    logic [1:0] points;
    dsa_pkg::t_phase phase;
    int         emit_pos, emit_low;

    t_sum_char  sum_chars_due[$];
    int         errors = 0;
    int         items_sent = 0;
    int         cycles = 0;
    bit         quiet = 1'b0;
    int         rx_hold = 0;

    function automatic void clear_problem();
        for (int k = 0; k < dsa_pkg::MAX_DIGITS; k++) begin
            dig_a[k] = '0;
            dig_b[k] = '0;
        end
        len_a = 0; len_b = 0; frac_a = 0; frac_b = 0; frac_kept = 0;
        points = '0;
        phase = dsa_pkg::PH_LOAD;
        emit_pos = 0;
        emit_low = 0;
    endfunction

    function automatic void take_char(logic sel, logic [7:0] c);
        if (c == dsa_pkg::CHAR_POINT) begin
            points[sel] = 1'b1;
        end else if (c >= dsa_pkg::CHAR_ZERO && c <= dsa_pkg::CHAR_NINE) begin
            if (!sel && len_a < dsa_pkg::MAX_DIGITS) begin
                dig_a[len_a] = 4'(c - dsa_pkg::CHAR_ZERO);
                len_a++;
                if (points[0]) frac_a++;
            end else if (sel && len_b < dsa_pkg::MAX_DIGITS) begin
                dig_b[len_b] = 4'(c - dsa_pkg::CHAR_ZERO);
                len_b++;
                if (points[1]) frac_b++;
            end
        end
    endfunction

    // Digit of an operand at an aligned place, place 0 being the lowest fraction digit.
    function automatic int aligned_digit(logic sel, int fmax, int p);
        int len, frac, idx;
        len = sel ? len_b : len_a;
        frac = sel ? frac_b : frac_a;
        idx = len - frac - 1 + fmax - p;
        if (idx < 0 || idx >= len) return 0;
        return sel ? int'(dig_b[idx]) : int'(dig_a[idx]);
    endfunction

    function automatic void add_numbers();
        int fmax, imax, w, drop, s, c, top;
        fmax = frac_a > frac_b ? frac_a : frac_b;
        imax = (len_a - frac_a) > (len_b - frac_b) ? (len_a - frac_a) : (len_b - frac_b);
        w = fmax + imax + 1;
        drop = w > dsa_pkg::SUM_DEPTH ? w - dsa_pkg::SUM_DEPTH : 0;
        c = 0;
        for (int p = 0; p < w; p++) begin
            s = aligned_digit(1'b0, fmax, p) + aligned_digit(1'b1, fmax, p) + c;
            c = (s >= 10) ? 1 : 0;
            if (c != 0) s -= 10;
            if (p >= drop && p - drop < dsa_pkg::SUM_DEPTH) sum_dig[p - drop] = 4'(s);
        end
        frac_kept = fmax - drop;
        top = w - drop - 1;
        while (top > frac_kept && sum_dig[top] == 0) top--;
        emit_low = 0;
        while (emit_low < frac_kept && sum_dig[emit_low] == 0) emit_low++;
        emit_pos = top;
        phase = dsa_pkg::PH_DIGIT;
    endfunction

    function automatic t_sum_char next_sum_char();
        t_sum_char r;
        r = '{8'h00, 1'b0, 1'b0};
        if (phase == dsa_pkg::PH_DIGIT) begin
            r.ch = dsa_pkg::CHAR_ZERO + 8'(sum_dig[emit_pos < dsa_pkg::SUM_DEPTH ?
                                                    emit_pos : dsa_pkg::SUM_DEPTH - 1]);
            if (emit_pos <= emit_low) begin
                r.lst = 1'b1;
                phase = dsa_pkg::PH_DONE;
            end else begin
                if (emit_pos == frac_kept) phase = dsa_pkg::PH_POINT;
                emit_pos--;
            end
        end else if (phase == dsa_pkg::PH_POINT) begin
            r.ch = dsa_pkg::CHAR_POINT;
            phase = dsa_pkg::PH_DIGIT;
        end else begin
            r.none = 1'b1;
        end
        return r;
    endfunction

    task automatic report(string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // Offers one request and returns at the falling edge after its transfer.
    task automatic send_req(logic req, logic sel, logic [7:0] c, logic lst);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 28) begin
            gap = $urandom_range(1, 3);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type = req;
        req_ch.operand_sel = sel;
        req_ch.char_code = c;
        req_ch.last_char = lst;
        req_ch.valid = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        if (req == dsa_pkg::REQ_LOAD) begin
            if (phase != dsa_pkg::PH_LOAD) clear_problem();
            take_char(sel, c);
            if (lst && sel) add_numbers();
        end else begin
            sum_chars_due.push_back(next_sum_char());
        end
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic send_operand(logic sel, t_chars s);
        if (s.size() == 0) begin
            if (sel) send_req(dsa_pkg::REQ_LOAD, 1'b1, dsa_pkg::CHAR_POINT, 1'b1);
            return;
        end
        foreach (s[k]) send_req(dsa_pkg::REQ_LOAD, sel, s[k], sel && k == s.size() - 1);
    endtask

    task automatic fetch_sum(int extra);
        while (phase == dsa_pkg::PH_DIGIT || phase == dsa_pkg::PH_POINT)
            send_req(dsa_pkg::REQ_FETCH, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat (extra) send_req(dsa_pkg::REQ_FETCH, 1'b0, 8'h00, 1'b0);
    endtask

    function automatic t_chars to_chars(string s);
        t_chars q;
        for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
        return q;
    endfunction

    function automatic t_chars random_number(int idig, int fdig, bit with_point);
        t_chars q;
        for (int k = 0; k < idig; k++)
            q.push_back(dsa_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        if (with_point) q.push_back(dsa_pkg::CHAR_POINT);
        for (int k = 0; k < fdig; k++)
            q.push_back(dsa_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        return q;
    endfunction

    task automatic add_pair(string a, string b);
        send_operand(1'b0, to_chars(a));
        send_operand(1'b1, to_chars(b));
        fetch_sum(1);
    endtask

    task automatic test_directed();
        send_req(dsa_pkg::REQ_FETCH, 1'b1, 8'hFF, 1'b1);
        add_pair("0", "0");
        add_pair("999", "1");
        add_pair(".5", ".5");
        add_pair("10", "0");
        add_pair("1.50", "2.30");
        add_pair("007", "0.0");
        add_pair("1.2.3", "9.99");
        send_req(dsa_pkg::REQ_LOAD, 1'b0, 8'h00, 1'b1);
        send_req(dsa_pkg::REQ_LOAD, 1'b0, 8'hFF, 1'b0);
        send_req(dsa_pkg::REQ_LOAD, 1'b0, dsa_pkg::CHAR_NINE, 1'b1);
        send_req(dsa_pkg::REQ_LOAD, 1'b1, 8'h41, 1'b1);
        fetch_sum(0);
        add_pair("12345", "");
        // A load in the middle of the emission starts a new problem.
        add_pair("98.7", "6");
        send_operand(1'b0, to_chars("123.45"));
        send_operand(1'b1, to_chars("1"));
        send_req(dsa_pkg::REQ_FETCH, 1'b0, 8'h00, 1'b0);
        send_req(dsa_pkg::REQ_FETCH, 1'b0, 8'h00, 1'b0);
        add_pair("5", "5");
    endtask

    task automatic test_capacity();
        send_operand(1'b0, random_number(300, 0, 1'b0));
        send_operand(1'b1, random_number(3, 2, 1'b1));
        fetch_sum(1);
        // Sum wider than the store: lowest fraction places are dropped.
        send_operand(1'b0, random_number(dsa_pkg::MAX_DIGITS, 0, 1'b0));
        send_operand(1'b1, random_number(0, dsa_pkg::MAX_DIGITS, 1'b1));
        fetch_sum(1);
    endtask

    task automatic test_backpressure();
        send_operand(1'b0, random_number(6, 3, 1'b1));
        send_operand(1'b1, random_number(5, 4, 1'b1));
        rx_hold = 400;
        fetch_sum(8);
        add_pair("1", "2");
    endtask

    task automatic test_random();
        int pick;
        t_chars a, b;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            quiet = items_sent > 700 && items_sent < 900;
            if (pick < 12) begin
                repeat ($urandom_range(1, 6))
                    send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                if (pick < 14)
                    a = random_number($urandom_range(1, 120), $urandom_range(0, 120), 1'b1);
                else
                    a = random_number($urandom_range(0, 8), $urandom_range(0, 6),
                                      1'($urandom_range(0, 1)));
                b = random_number($urandom_range(0, 8), $urandom_range(0, 6),
                                  1'($urandom_range(0, 1)));
                if (pick < 22 && a.size() > 0)
                    a.insert($urandom_range(0, a.size() - 1), 8'($urandom_range(0, 255)));
                send_operand(1'b0, a);
                send_operand(1'b1, b);
                if (pick < 30)
                    repeat ($urandom_range(0, 3))
                        send_req(dsa_pkg::REQ_FETCH, 1'b0, 8'h00, 1'b0);
                else fetch_sum($urandom_range(0, 2));
            end
        end
        quiet = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            sum_ch.ready <= 1'b0;
        end else begin
            sum_ch.ready <= i_rst_n && (quiet || $urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge i_clk) begin
        t_sum_char due;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("decimal_string_adder_tb: errors");
            $finish;
        end
        if (i_rst_n && sum_ch.valid && sum_ch.ready) begin
            if (sum_chars_due.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                due = sum_chars_due.pop_front();
                if (sum_ch.out_char !== due.ch)
                    report($sformatf("char %h, expected %h", sum_ch.out_char, due.ch));
                if (sum_ch.out_last !== due.lst)
                    report($sformatf("last %b, expected %b", sum_ch.out_last, due.lst));
                if (sum_ch.out_none !== due.none)
                    report($sformatf("none %b, expected %b", sum_ch.out_none, due.none));
            end
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = dsa_pkg::REQ_LOAD;
        req_ch.operand_sel = 1'b0;
        req_ch.char_code = 8'h00;
        req_ch.last_char = 1'b0;
        sum_ch.ready = 1'b0;
        clear_problem();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_capacity();
        test_backpressure();
        test_random();
        while (sum_chars_due.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        if (errors == 0)
            $display("decimal_string_adder_tb: clean");
        else
            $display("decimal_string_adder_tb: errors");
        $finish;
    end

endmodule

### sim.f
rtl/core/dsa_pkg.sv
rtl/core/dsa_if.sv
rtl/core/dsa_ram.sv
rtl/core/dsa_bcd_unit.sv
rtl/core/decimal_string_adder.sv
dv/decimal_string_adder_tb.sv
